/* rtl/core/dic_pkg.sv */
// ============================================================================
// Duplicate id cache package
// Shared types, command codes and defaults for the duplicate id cache.
// ============================================================================
package dic_pkg;

    localparam int          ENTRIES_DEF  = 32;
    localparam int          WORD_W       = 32;
    localparam int          CNT_OUT_W    = 6;
    localparam logic [31:0] LIFETIME_RST = 32'd3000;

    typedef enum logic [1:0] {
        CMD_CHECK_INSERT = 2'd0,
        CMD_LOOKUP       = 2'd1,
        CMD_INSERT       = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] address;
        logic [WORD_W-1:0] identifier;
        logic [WORD_W-1:0] expiry;
    } t_entry;

    typedef struct packed {
        logic [1:0]        command;
        logic [WORD_W-1:0] source_address;
        logic [WORD_W-1:0] request_id;
        logic [WORD_W-1:0] current_time;
    } t_item;

    typedef struct packed {
        logic                 match_found;
        logic                 entry_stored;
        logic                 table_full;
        logic [CNT_OUT_W-1:0] live_count;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic rd;
        logic store;
        logic finish;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/core/dic_req_if.sv */
// ============================================================================
// Request channel
// Valid/ready channel carrying one cache command transaction.
// ============================================================================
interface dic_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] source_address;
    logic [31:0] request_id;
    logic [31:0] current_time;

    modport source (
        output valid, command, source_address, request_id, current_time,
        input  ready
    );
    modport sink (
        input  valid, command, source_address, request_id, current_time,
        output ready
    );
endinterface

/* rtl/core/dic_rsp_if.sv */
// ============================================================================
// Response channel
// Valid/ready channel carrying one cache result transaction.
// ============================================================================
interface dic_rsp_if;
    logic       valid;
    logic       ready;
    logic       match_found;
    logic       entry_stored;
    logic       table_full;
    logic [5:0] live_count;

    modport source (
        output valid, match_found, entry_stored, table_full, live_count,
        input  ready
    );
    modport sink (
        input  valid, match_found, entry_stored, table_full, live_count,
        output ready
    );
endinterface

/* rtl/core/dic_cfg_if.sv */
// ============================================================================
// Configuration channel
// Valid/ready write channel for the entry lifetime register.
// ============================================================================
interface dic_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

/* rtl/core/dic_ram.sv */
// ============================================================================
// Generic RAM
// One write port, one read port, registered read data.
// ============================================================================
module dic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dic_ctrl.sv */
// ============================================================================
// Cache controller
// Sequences the clearing pass, the table scan, the store and the result.
// ============================================================================
module dic_ctrl
    import dic_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  t_dp_stat                   i_stat,
    output t_dp_cmd                    o_cmd,
    output logic [$clog2(ENTRIES)-1:0] o_idx
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_STORE,
        S_FINISH
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

/* rtl/core/dic_dp.sv */
// ============================================================================
// Cache datapath
// Entry table, scan evaluation, store logic and result register.
// ============================================================================
module dic_dp
    import dic_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic [$clog2(ENTRIES)-1:0] i_idx,
    output t_dp_stat                   o_stat,
    input  t_item                      i_item,
    input  logic                       i_cfg_we,
    input  logic [WORD_W-1:0]          i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_result                    o_result
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int CWX = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
    localparam int EW  = $bits(t_entry);

    logic [WORD_W-1:0] r_lifetime;
    t_item             r_item;
    logic              r_eval;
    logic [IW-1:0]     r_eval_idx;
    logic              r_match;
    logic              r_free_found;
    logic [IW-1:0]     r_free_idx;
    logic [CW-1:0]     r_cnt;
    logic              r_stored;
    logic              r_full;
    logic              r_out_valid;
    t_result           r_out;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic [EW-1:0]     ram_rdata;
    t_entry            rd_entry;
    logic              e_expired;
    logic              e_live;
    logic              e_hit;
    logic              do_search;
    logic              need_store;
    logic [WORD_W:0]   exp_sum;
    logic [WORD_W-1:0] exp_sat;
    logic [CWX-1:0]    cnt_x;

    dic_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = t_entry'(ram_rdata);
    assign e_expired = rd_entry.valid && (rd_entry.expiry < r_item.current_time);
    assign e_live    = rd_entry.valid && !e_expired;
    assign do_search = (r_item.command == CMD_CHECK_INSERT) || (r_item.command == CMD_LOOKUP);
    assign e_hit     = e_live && do_search
                       && (rd_entry.address == r_item.source_address)
                       && (rd_entry.identifier == r_item.request_id);
    assign need_store = (r_item.command == CMD_INSERT)
                        || ((r_item.command == CMD_CHECK_INSERT) && !r_match);

    assign exp_sum = {1'b0, r_item.current_time} + {1'b0, r_lifetime};
    assign exp_sat = exp_sum[WORD_W] ? '1 : exp_sum[WORD_W-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_eval_idx;
        ram_wdata = rd_entry;
        if (i_cmd.clear_wr) begin
            ram_we    = 1'b1;
            ram_waddr = i_idx;
            ram_wdata = '0;
        end else if (i_cmd.store) begin
            ram_we               = need_store && r_free_found;
            ram_waddr            = r_free_idx;
            ram_wdata.valid      = 1'b1;
            ram_wdata.address    = r_item.source_address;
            ram_wdata.identifier = r_item.request_id;
            ram_wdata.expiry     = exp_sat;
        end else if (r_eval && e_expired) begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime  <= LIFETIME_RST;
            r_eval      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lifetime <= i_cfg_data;
            end
            r_eval <= i_cmd.rd;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= i_idx;
        if (i_cmd.load) begin
            r_item       <= i_item;
            r_match      <= 1'b0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_cnt        <= '0;
            r_stored     <= 1'b0;
            r_full       <= 1'b0;
        end else if (r_eval) begin
            if (e_hit) begin
                r_match <= 1'b1;
            end
            if (e_live) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_eval_idx;
            end
        end else if (i_cmd.store) begin
            if (need_store && r_free_found) begin
                r_stored <= 1'b1;
                r_cnt    <= r_cnt + 1'b1;
            end else if (need_store) begin
                r_full <= 1'b1;
            end
        end
        if (i_cmd.finish) begin
            r_out.match_found  <= r_match;
            r_out.entry_stored <= r_stored;
            r_out.table_full   <= r_full;
            r_out.live_count   <= (cnt_x > CWX'(63)) ? 6'd63 : cnt_x[CNT_OUT_W-1:0];
        end
    end

    assign cnt_x           = CWX'(r_cnt);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_result        = r_out;

endmodule

/* rtl/core/duplicate_id_cache_with_expiry_unit.sv */
// ============================================================================
// Duplicate id cache with expiry
// Table of recently seen (source address, request id) pairs with expiry.
// ============================================================================
// Each request transaction scans the whole table through the single read
// port of the entry RAM, retiring expired entries, looking for a live match
// and picking the lowest free slot, then optionally stores the pair. A
// transaction runs through the scan, a drain step and the store, then
// loads its result into the output register once that register is free;
// only then is the next request accepted. The next request is taken while
// an earlier result still waits in the output register. After reset a
// clearing pass empties the table before the first request is accepted;
// lifetime writes are taken at any time.
module duplicate_id_cache_with_expiry_unit
    import dic_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dic_req_if.sink   i_req,
    dic_rsp_if.source o_rsp,
    dic_cfg_if.sink   i_cfg
);

    t_dp_cmd                    cmd;
    t_dp_stat                   stat;
    logic [$clog2(ENTRIES)-1:0] idx;
    t_item                      item;
    t_result                    result;

    assign item.command        = i_req.command;
    assign item.source_address = i_req.source_address;
    assign item.request_id     = i_req.request_id;
    assign item.current_time   = i_req.current_time;

    assign i_cfg.ready = 1'b1;

    dic_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_idx       (idx)
    );

    dic_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .o_stat      (stat),
        .i_item      (item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_result    (result)
    );

    assign o_rsp.match_found  = result.match_found;
    assign o_rsp.entry_stored = result.entry_stored;
    assign o_rsp.table_full   = result.table_full;
    assign o_rsp.live_count   = result.live_count;

endmodule

/* test/cache_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// Duplicate id cache checker
// Watches the request, result and lifetime channels, keeps its own copy of
// the cache table, predicts one result per request and compares in order.
// ============================================================================
module cache_checker
    import dic_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dic_req_if   req,
    dic_rsp_if   rsp,
    dic_cfg_if   cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_req_count,
    output int   o_hit_count,
    output int   o_store_count,
    output int   o_full_count
);

    logic [ENTRIES-1:0] tbl_valid;
    logic [31:0]        tbl_addr   [ENTRIES];
    logic [31:0]        tbl_id     [ENTRIES];
    logic [31:0]        tbl_expiry [ENTRIES];
    logic [31:0]        lifetime;
    t_result            expected_q [$];

    function automatic t_result predict_request(input t_item it);
        t_result     res;
        logic [32:0] sum;
        logic        hit;
        logic        want_store;
        int          free_slot;
        int          live;
        res        = '0;
        hit        = 1'b0;
        want_store = 1'b0;
        free_slot  = -1;
        live       = 0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (tbl_valid[k] && tbl_expiry[k] < it.current_time) tbl_valid[k] = 1'b0;
        end
        for (int k = 0; k < ENTRIES; k++) begin
            if (tbl_valid[k] && tbl_addr[k] == it.source_address &&
                tbl_id[k] == it.request_id) hit = 1'b1;
        end
        case (it.command)
            CMD_CHECK_INSERT: begin
                res.match_found = hit;
                want_store      = !hit;
            end
            CMD_LOOKUP: begin
                res.match_found = hit;
            end
            CMD_INSERT: begin
                want_store = 1'b1;
            end
            default: ;
        endcase
        if (want_store) begin
            for (int k = ENTRIES - 1; k >= 0; k--) begin
                if (!tbl_valid[k]) free_slot = k;
            end
            if (free_slot < 0) begin
                res.table_full = 1'b1;
            end else begin
                sum                   = {1'b0, it.current_time} + {1'b0, lifetime};
                tbl_valid[free_slot]  = 1'b1;
                tbl_addr[free_slot]   = it.source_address;
                tbl_id[free_slot]     = it.request_id;
                tbl_expiry[free_slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                res.entry_stored      = 1'b1;
            end
        end
        for (int k = 0; k < ENTRIES; k++) live += tbl_valid[k];
        res.live_count = (live > 63) ? CNT_OUT_W'(63) : CNT_OUT_W'(live);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_res;
        t_result got;
        if (!i_rst_n) begin
            tbl_valid = '0;
            lifetime  = LIFETIME_RST;
            expected_q.delete();
            o_fail_count  = 0;
            o_req_count   = 0;
            o_hit_count   = 0;
            o_store_count = 0;
            o_full_count  = 0;
        end else begin
            if (cfg.valid && cfg.ready) lifetime = cfg.data;
            if (req.valid && req.ready) begin
                expected_q.insert(expected_q.size(), predict_request(t_item'{req.command,
                    req.source_address, req.request_id, req.current_time}));
                o_req_count++;
            end
            if (rsp.valid && rsp.ready) begin
                got = t_result'{rsp.match_found, rsp.entry_stored, rsp.table_full,
                                rsp.live_count};
                o_hit_count   += got.match_found;
                o_store_count += got.entry_stored;
                o_full_count  += got.table_full;
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result transaction with none outstanding", $time);
                end else begin
                    exp_res = expected_q.pop_front();
                    if (got !== exp_res) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: mismatch expected match=%0b stored=%0b ",
                                      "full=%0b live=%0d, got match=%0b stored=%0b ",
                                      "full=%0b live=%0d"}, $time,
                                     exp_res.match_found, exp_res.entry_stored,
                                     exp_res.table_full, exp_res.live_count,
                                     got.match_found, got.entry_stored,
                                     got.table_full, got.live_count);
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// Duplicate id cache testbench
// Directed checks of duplicates, expiry edges, saturation and the unused
// command, then random phases over several lifetimes with random idling.
// ============================================================================
module testbench;
    import dic_pkg::*;

    localparam int          ENTRIES     = ENTRIES_DEF;
    localparam int          SETTLE      = ENTRIES + 8;
    localparam int          STALL_LIMIT = 2000;
    localparam int          PHASES      = 10;
    localparam int          PHASE_ITEMS = 185;
    localparam int          POOL        = 12;
    localparam int          QUIET_PHASE = 3;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [31:0] MAX_WORD    = 32'hFFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic stall_en;

    int fail_count, pending, req_count, hit_count, store_count, full_count;
    int quiet_cycles = 0;
    int cfg_writes   = 0;

    logic [31:0] phase_life [PHASES];
    logic [31:0] pool_addr  [POOL];
    logic [31:0] pool_id    [POOL];
    logic [31:0] now, lifetime, step_max, jump_max, addr, id, step;
    logic [1:0]  cmd;
    int unsigned roll, pick;

    dic_req_if req_bus ();
    dic_rsp_if rsp_bus ();
    dic_cfg_if cfg_bus ();

    duplicate_id_cache_with_expiry_unit #(.ENTRIES(ENTRIES)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    cache_checker #(.ENTRIES(ENTRIES)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req           (req_bus),
        .rsp           (rsp_bus),
        .cfg           (cfg_bus),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_req_count   (req_count),
        .o_hit_count   (hit_count),
        .o_store_count (store_count),
        .o_full_count  (full_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        rsp_bus.ready <= !stall_en || ($urandom_range(99) >= 35);
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] time_after(input logic [31:0] t, input logic [31:0] d);
        logic [32:0] s;
        s = {1'b0, t} + {1'b0, d};
        return s[32] ? MAX_WORD : s[31:0];
    endfunction

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0) return '0;
        if (r == 1) return MAX_WORD;
        return $urandom;
    endfunction

    task automatic send_request(input logic [1:0] c, input logic [31:0] a,
                                input logic [31:0] r, input logic [31:0] t);
        while (stall_en && $urandom_range(99) < 35) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.command        <= c;
        req_bus.source_address <= a;
        req_bus.request_id     <= r;
        req_bus.current_time   <= t;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_lifetime(input logic [31:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        stall_en               <= 1'b1;
        req_bus.valid          <= 1'b0;
        req_bus.command        <= CMD_CHECK_INSERT;
        req_bus.source_address <= '0;
        req_bus.request_id     <= '0;
        req_bus.current_time   <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.data           <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset lifetime: duplicates, expiry edge, double insert, partial matches
        send_request(CMD_CHECK_INSERT, 32'h0A00_0001, 32'd1, 32'd100);
        send_request(CMD_CHECK_INSERT, 32'h0A00_0001, 32'd1, 32'd100);
        send_request(CMD_LOOKUP,       32'h0A00_0001, 32'd1, 32'd3100);
        send_request(CMD_LOOKUP,       32'h0A00_0001, 32'd1, 32'd3101);
        send_request(CMD_INSERT,       32'hC0A8_0102, MAX_WORD, 32'd3101);
        send_request(CMD_INSERT,       32'hC0A8_0102, MAX_WORD, 32'd3101);
        send_request(CMD_LOOKUP,       32'hC0A8_0102, MAX_WORD, 32'd3101);
        send_request(CMD_UNUSED,       32'hC0A8_0102, MAX_WORD, 32'd3101);
        send_request(CMD_CHECK_INSERT, 32'h0,         32'h0,    32'd3101);
        send_request(CMD_CHECK_INSERT, MAX_WORD,      MAX_WORD, 32'd3101);
        send_request(CMD_LOOKUP,       32'h0,         MAX_WORD, 32'd3101);
        send_request(CMD_LOOKUP,       MAX_WORD,      32'h0,    32'd3101);
        drain();
        write_lifetime('0);
        send_request(CMD_CHECK_INSERT, 32'h0A00_0004, 32'd9, 32'd5000);
        send_request(CMD_LOOKUP,       32'h0A00_0004, 32'd9, 32'd5000);
        send_request(CMD_LOOKUP,       32'h0A00_0004, 32'd9, 32'd5001);
        drain();
        write_lifetime(MAX_WORD);
        send_request(CMD_CHECK_INSERT, 32'h0A00_0003, 32'd7, 32'hFFFF_FF00);
        send_request(CMD_LOOKUP,       32'h0A00_0003, 32'd7, MAX_WORD);

        phase_life = '{32'd3000, 32'd0, 32'd40, 32'd1, 32'd500, 32'd12,
                       32'd0, 32'd7, 32'd0, MAX_WORD};
        phase_life[6] = $urandom_range(1000, 100000);
        phase_life[8] = $urandom;
        now = 32'd10000;

        for (int p = 0; p < PHASES; p++) begin
            drain();
            lifetime = phase_life[p];
            write_lifetime(lifetime);
            stall_en <= (p != QUIET_PHASE);
            if (p == 8)
                now = time_after(now, $urandom);
            else if (p == PHASES - 1 && now < MAX_WORD - 32'd200000)
                now = MAX_WORD - $urandom_range(0, 200000);
            else
                now = time_after(now, $urandom_range(1000, 100000));
            step_max = (lifetime > 32'd1600000) ? 32'd100000 : lifetime / 16 + 1;
            jump_max = (lifetime > 32'd1000000) ? 32'd1000002 : lifetime + 2;
            for (int i = 0; i < POOL; i++) begin
                pool_addr[i] = pick_word();
                pool_id[i]   = pick_word();
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                roll = $urandom_range(99);
                cmd  = (roll < 45) ? CMD_CHECK_INSERT :
                       (roll < 70) ? CMD_LOOKUP :
                       (roll < 95) ? CMD_INSERT : CMD_UNUSED;
                if ($urandom_range(99) < 65) begin
                    pick = $urandom_range(POOL - 1);
                    addr = pool_addr[pick];
                    id   = pool_id[pick];
                end else begin
                    addr = pick_word();
                    id   = pick_word();
                end
                step = ($urandom_range(99) < 5) ? $urandom_range(0, jump_max)
                                                : $urandom_range(0, step_max);
                now  = time_after(now, step);
                send_request(cmd, addr, id, now);
            end
        end
        drain();
        @(negedge i_clk);

        $display("Covered %0d requests over %0d lifetime settings, zero and all-ones included.",
                 req_count, cfg_writes + 1);
        $display("Results saw %0d duplicate hits, %0d stores and %0d table-full drops.",
                 hit_count, store_count, full_count);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/dic_pkg.sv
rtl/core/dic_req_if.sv
rtl/core/dic_rsp_if.sv
rtl/core/dic_cfg_if.sv
rtl/core/dic_ram.sv
rtl/core/dic_ctrl.sv
rtl/core/dic_dp.sv
rtl/core/duplicate_id_cache_with_expiry_unit.sv
test/cache_checker.sv
test/testbench.sv
